@@ hdl/srt_pkg.sv @@
// ============================================================================
// srt_pkg
// Shared types, codes and helpers for the sorted record table.
// ============================================================================
`default_nettype none

package srt_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int TEXT_CHARS   = 8;
    localparam int MAX_RESULTS  = 16;

    localparam int ACT_W    = 3;
    localparam int YEAR_W   = 14;
    localparam int TEXT_W   = 64;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 4;
    localparam int HIT_W    = $clog2(MAX_RESULTS + 1);

    // action codes
    localparam logic [ACT_W-1:0] ACT_INSERT  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_LIST    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_YEAR_EQ = 3'd2;
    localparam logic [ACT_W-1:0] ACT_YEAR_GE = 3'd3;
    localparam logic [ACT_W-1:0] ACT_MODEL   = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RECORD   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NONE     = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_SHIFT,
        S_INS_PUT,
        S_Q_SCAN,
        S_Q_END
    } srt_state_t;

    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic [TEXT_W-1:0] brand;
        logic [TEXT_W-1:0] model;
        logic [TEXT_W-1:0] plate;
    } srt_rec_t;

    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
        srt_rec_t            rec;
        logic [POS_W-1:0]    pos;
        logic                last;
    } srt_emit_t;

    // Keep only the low TEXT_CHARS bytes.
    function automatic logic [TEXT_W-1:0] text_mask(input logic [TEXT_W-1:0] v);
        logic [TEXT_W-1:0] m;
        m = '0;
        for (int k = 0; k < TEXT_W / 8; k++) begin
            if (k < TEXT_CHARS) begin
                m[8*k +: 8] = 8'hFF;
            end
        end
        return v & m;
    endfunction

    // String compare: equal up to and including the first zero byte.
    function automatic logic same_text(input logic [TEXT_W-1:0] a,
                                       input logic [TEXT_W-1:0] b);
        logic eq;
        logic stop;
        eq   = 1'b1;
        stop = 1'b0;
        for (int k = 0; k < TEXT_CHARS; k++) begin
            if (!stop) begin
                if (a[8*k +: 8] != b[8*k +: 8]) begin
                    eq   = 1'b0;
                    stop = 1'b1;
                end
                else if (a[8*k +: 8] == 8'h00) begin
                    stop = 1'b1;
                end
            end
        end
        return eq;
    endfunction

endpackage

`default_nettype wire

@@ hdl/srt_ram.sv @@
// ============================================================================
// srt_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module srt_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ hdl/srt_engine.sv @@
// ============================================================================
// srt_engine
// Sequencer for the record table: walks the record memory one entry per
// cycle to shift records for an insert or to scan them for a query.
// ============================================================================
`default_nettype none

module srt_engine
    import srt_pkg::*;
#(
    parameter  int CAPACITY = CAPACITY_DEF,
    localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CW       = $clog2(CAPACITY + 1)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [ACT_W-1:0]  action,
    input  wire logic [YEAR_W-1:0] key_year,
    input  wire logic [TEXT_W-1:0] brand_text,
    input  wire logic [TEXT_W-1:0] model_text,
    input  wire logic [TEXT_W-1:0] plate_text,
    output logic                   busy,
    output logic                   we,
    output logic      [AW-1:0]     waddr,
    output srt_rec_t               wdata,
    output logic      [AW-1:0]     raddr,
    input  wire srt_rec_t          rdata,
    output srt_emit_t              emit
);

    srt_state_t state_reg, state_next;

    logic [CW-1:0]    count_reg, count_next;
    logic [AW-1:0]    idx_reg, idx_next;
    logic [AW-1:0]    pos_reg, pos_next;
    logic [HIT_W-1:0] hits_reg, hits_next;
    logic             pend_valid_reg, pend_valid_next;

    logic [ACT_W-1:0] act_reg, act_next;
    srt_rec_t         key_reg, key_next;
    srt_rec_t         pend_reg, pend_next;
    logic [AW-1:0]    pend_pos_reg, pend_pos_next;

    logic          full;
    logic [AW-1:0] last_idx;
    logic          hit;
    logic          at_end;
    logic          scan_stop;
    logic          year_ge;

    assign full      = (count_reg == CW'(CAPACITY));
    assign last_idx  = AW'(count_reg - CW'(1));
    assign year_ge   = (rdata.year >= key_reg.year);
    assign at_end    = ((CW'(idx_reg) + CW'(1)) == count_reg);
    assign scan_stop = (hit && (hits_reg == HIT_W'(MAX_RESULTS - 1))) || at_end;
    assign busy      = (state_reg != S_IDLE);

    always_comb
    begin
        case (act_reg)
            ACT_LIST:    hit = 1'b1;
            ACT_YEAR_EQ: hit = (rdata.year == key_reg.year);
            ACT_YEAR_GE: hit = year_ge;
            ACT_MODEL:   hit = same_text(rdata.model, key_reg.model);
            default:     hit = 1'b0;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (action == ACT_INSERT)
                    begin
                        if (full)
                            state_next = S_IDLE;
                        else if (count_reg == '0)
                            state_next = S_INS_PUT;
                        else
                            state_next = S_INS_SHIFT;
                    end
                    else if (action inside {[ACT_LIST:ACT_MODEL]})
                    begin
                        state_next = (count_reg == '0) ? S_Q_END : S_Q_SCAN;
                    end
                end
            end
            S_INS_SHIFT:
            begin
                if (!(year_ge && idx_reg != '0))
                    state_next = S_INS_PUT;
            end
            S_INS_PUT:   state_next = S_IDLE;
            S_Q_SCAN:
            begin
                if (scan_stop)
                    state_next = S_Q_END;
            end
            S_Q_END:     state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // datapath, memory access and results
    always_comb
    begin
        count_next      = count_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        hits_next       = hits_reg;
        pend_valid_next = pend_valid_reg;
        act_next        = act_reg;
        key_next        = key_reg;
        pend_next       = pend_reg;
        pend_pos_next   = pend_pos_reg;
        we              = 1'b0;
        waddr           = idx_reg + AW'(1);
        wdata           = rdata;
        raddr           = idx_reg;
        emit            = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    act_next       = action;
                    key_next.year  = key_year;
                    key_next.brand = text_mask(brand_text);
                    key_next.model = text_mask(model_text);
                    key_next.plate = text_mask(plate_text);
                    if (action == ACT_INSERT)
                    begin
                        if (full)
                        begin
                            emit.valid  = 1'b1;
                            emit.status = ST_FULL;
                            emit.last   = 1'b1;
                        end
                        // walk down from the top record
                        idx_next = last_idx;
                        raddr    = last_idx;
                        pos_next = '0;
                    end
                    else
                    begin
                        idx_next        = '0;
                        raddr           = '0;
                        hits_next       = '0;
                        pend_valid_next = 1'b0;
                    end
                end
            end
            S_INS_SHIFT:
            begin
                if (year_ge)
                begin
                    // move this record up by one
                    we    = 1'b1;
                    waddr = idx_reg + AW'(1);
                    wdata = rdata;
                    if (idx_reg != '0)
                    begin
                        idx_next = idx_reg - AW'(1);
                        raddr    = idx_reg - AW'(1);
                    end
                    else
                    begin
                        pos_next = '0;
                    end
                end
                else
                begin
                    pos_next = idx_reg + AW'(1);
                end
            end
            S_INS_PUT:
            begin
                we          = 1'b1;
                waddr       = pos_reg;
                wdata       = key_reg;
                count_next  = count_reg + CW'(1);
                emit.valid  = 1'b1;
                emit.status = ST_INSERTED;
                emit.rec    = key_reg;
                emit.pos    = POS_W'(pos_reg);
                emit.last   = 1'b1;
            end
            S_Q_SCAN:
            begin
                // hold one match back until it is known whether it is the last
                if (hit)
                begin
                    if (pend_valid_reg)
                    begin
                        emit.valid  = 1'b1;
                        emit.status = ST_RECORD;
                        emit.rec    = pend_reg;
                        emit.pos    = POS_W'(pend_pos_reg);
                        emit.last   = 1'b0;
                    end
                    pend_next       = rdata;
                    pend_pos_next   = idx_reg;
                    pend_valid_next = 1'b1;
                    hits_next       = hits_reg + HIT_W'(1);
                end
                if (!scan_stop)
                begin
                    idx_next = idx_reg + AW'(1);
                    raddr    = idx_reg + AW'(1);
                end
            end
            S_Q_END:
            begin
                emit.valid = 1'b1;
                emit.last  = 1'b1;
                if (pend_valid_reg)
                begin
                    emit.status = ST_RECORD;
                    emit.rec    = pend_reg;
                    emit.pos    = POS_W'(pend_pos_reg);
                end
                else
                begin
                    emit.status = ST_NONE;
                end
            end
            default:
            begin
                emit = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            idx_reg        <= '0;
            pos_reg        <= '0;
            hits_reg       <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            pos_reg        <= pos_next;
            hits_reg       <= hits_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        key_reg      <= key_next;
        pend_reg     <= pend_next;
        pend_pos_reg <= pend_pos_next;
    end

endmodule

`default_nettype wire

@@ hdl/sorted_record_table_core.sv @@
// ============================================================================
// sorted_record_table_core
// Table of records kept in ascending year order, with insert and queries.
// ============================================================================
//
//  Channel  Signals                                        Transfer
//  -------  ---------------------------------------------  ---------------------
//  command  start, busy, action, key_year, brand_text,     start && !busy
//           model_text, plate_text
//  result   strobe, status, out_year, out_brand,           every strobe cycle
//           out_model, out_plate, out_position, last
//
//  Records sit in one memory read once per cycle, so work is one record a cycle.
//  Insert: busy while records at or above the new year move up a place and the new
//  record is written; a full table leaves busy low. Query: busy while the stored
//  records are scanned, stopping early once 16 matches are found.
//  Results appear from a register in the cycle after they are formed; the receiver
//  cannot stall them. Reset empties the table at once, with no clearing pass.
//
`default_nettype none

module sorted_record_table_core
    import srt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [ACT_W-1:0]    action,
    input  wire logic [YEAR_W-1:0]   key_year,
    input  wire logic [TEXT_W-1:0]   brand_text,
    input  wire logic [TEXT_W-1:0]   model_text,
    input  wire logic [TEXT_W-1:0]   plate_text,
    output logic                     strobe,
    output logic      [STATUS_W-1:0] status,
    output logic      [YEAR_W-1:0]   out_year,
    output logic      [TEXT_W-1:0]   out_brand,
    output logic      [TEXT_W-1:0]   out_model,
    output logic      [TEXT_W-1:0]   out_plate,
    output logic      [POS_W-1:0]    out_position,
    output logic                     last
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic          we;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    srt_rec_t      wdata;
    srt_rec_t      rdata;
    srt_emit_t     emit;

    logic                strobe_reg;
    logic [STATUS_W-1:0] status_reg;
    srt_rec_t            rec_reg;
    logic [POS_W-1:0]    pos_reg;
    logic                last_reg;

    srt_ram #(
        .WIDTH ($bits(srt_rec_t)),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    srt_engine #(
        .CAPACITY (CAPACITY)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .action     (action),
        .key_year   (key_year),
        .brand_text (brand_text),
        .model_text (model_text),
        .plate_text (plate_text),
        .busy       (busy),
        .we         (we),
        .waddr      (waddr),
        .wdata      (wdata),
        .raddr      (raddr),
        .rdata      (rdata),
        .emit       (emit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= emit.valid;
        end
    end

    // hold the payload until the next result
    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            status_reg <= emit.status;
            rec_reg    <= emit.rec;
            pos_reg    <= emit.pos;
            last_reg   <= emit.last;
        end
    end

    assign strobe       = strobe_reg;
    assign status       = status_reg;
    assign out_year     = rec_reg.year;
    assign out_brand    = rec_reg.brand;
    assign out_model    = rec_reg.model;
    assign out_plate    = rec_reg.plate;
    assign out_position = pos_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire

@@ hdl/srt_checker.sv @@
// ============================================================================
// srt_checker
// Port-level checks on the record table's result stream.
// ============================================================================
`default_nettype none

module srt_checker
    import srt_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire logic                strobe,
    input wire logic [STATUS_W-1:0] status,
    input wire logic [YEAR_W-1:0]   out_year,
    input wire logic [POS_W-1:0]    out_position,
    input wire logic                last
);

    // a result only follows a transfer or work in progress
    a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> ($past(busy) || $past(start)))
        else $error("result without a command in progress");

    // more results still to come keep the block busy
    a_not_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |-> busy)
        else $error("non-final result while idle");

    // insert, full and none-found are always single results
    a_single_results: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && (status == ST_INSERTED || status == ST_FULL || status == ST_NONE))
            |-> last)
        else $error("single-result status without last");

    // full and none-found carry cleared fields
    a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && (status == ST_FULL || status == ST_NONE))
            |-> (out_year == '0 && out_position == '0))
        else $error("full or none-found result with non-zero fields");

endmodule

bind sorted_record_table_core srt_checker u_srt_checker (.*);

`default_nettype wire

@@ tb/tb.sv @@
// ============================================================================
// tb
// Checks the sorted record table: inserts, full table, and the four queries.
// A shadow table predicts every reply; a monitor compares each strobed reply
// field by field with the oldest prediction.
// ============================================================================
`default_nettype none

module tb;
    import srt_pkg::*;

    localparam int LIMIT_CYCLES = 200_000;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [TEXT_W-1:0] TEXT_KEEP =
        (TEXT_CHARS >= 8) ? {TEXT_W{1'b1}} : ((64'd1 << (8 * TEXT_CHARS)) - 64'd1);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        srt_rec_t            rec;
        logic [POS_W-1:0]    pos;
        logic                last;
    } table_reply_t;

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                start      = 1'b0;
    logic [ACT_W-1:0]    action     = ACT_INSERT;
    logic [YEAR_W-1:0]   key_year   = '0;
    logic [TEXT_W-1:0]   brand_text = '0;
    logic [TEXT_W-1:0]   model_text = '0;
    logic [TEXT_W-1:0]   plate_text = '0;
    logic                busy;
    logic                strobe;
    logic [STATUS_W-1:0] status;
    logic [YEAR_W-1:0]   out_year;
    logic [TEXT_W-1:0]   out_brand;
    logic [TEXT_W-1:0]   out_model;
    logic [TEXT_W-1:0]   out_plate;
    logic [POS_W-1:0]    out_position;
    logic                last;

    // shadow copy of the table
    srt_rec_t     shadow_rec [CAPACITY_DEF];
    int           shadow_count = 0;
    table_reply_t pending_replies [$];
    table_reply_t oldest_reply;

    int mismatches  = 0;
    int cycle_count = 0;
    bit gaps_on     = 1'b1;

    sorted_record_table_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .key_year     (key_year),
        .brand_text   (brand_text),
        .model_text   (model_text),
        .plate_text   (plate_text),
        .strobe       (strobe),
        .status       (status),
        .out_year     (out_year),
        .out_brand    (out_brand),
        .out_model    (out_model),
        .out_plate    (out_plate),
        .out_position (out_position),
        .last         (last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // string compare: equal when no byte differs, or a shared zero byte
    // comes before the first difference
    function automatic logic models_match(input logic [TEXT_W-1:0] a,
                                          input logic [TEXT_W-1:0] b);
        int diff_at;
        int zero_at;
        int k;
        diff_at = TEXT_CHARS;
        zero_at = TEXT_CHARS;
        for (k = TEXT_CHARS - 1; k >= 0; k--)
        begin
            if (a[8*k +: 8] != b[8*k +: 8])
                diff_at = k;
            if (a[8*k +: 8] == 8'h00)
                zero_at = k;
        end
        return (diff_at == TEXT_CHARS) || (zero_at < diff_at);
    endfunction

    task automatic apply_table_command(input logic [ACT_W-1:0]  act,
                                       input logic [YEAR_W-1:0] yr,
                                       input logic [TEXT_W-1:0] br,
                                       input logic [TEXT_W-1:0] md,
                                       input logic [TEXT_W-1:0] pl);
        table_reply_t r;
        table_reply_t held;
        int           slot;
        int           i;
        int           hits;
        logic         hit;
        r      = '0;
        r.last = 1'b1;
        held   = '0;
        hits   = 0;
        if (act == ACT_INSERT)
        begin
            if (shadow_count >= CAPACITY_DEF)
            begin
                r.status = ST_FULL;
                pending_replies.push_back(r);
            end
            else
            begin
                slot = 0;
                while (slot < shadow_count && shadow_rec[slot].year < yr)
                    slot++;
                for (i = shadow_count; i > slot; i--)
                    shadow_rec[i] = shadow_rec[i-1];
                shadow_rec[slot].year  = yr;
                shadow_rec[slot].brand = br & TEXT_KEEP;
                shadow_rec[slot].model = md & TEXT_KEEP;
                shadow_rec[slot].plate = pl & TEXT_KEEP;
                shadow_count++;
                r.status = ST_INSERTED;
                r.rec    = shadow_rec[slot];
                r.pos    = slot[POS_W-1:0];
                pending_replies.push_back(r);
            end
        end
        else if (act <= ACT_MODEL)
        begin
            for (i = 0; i < shadow_count && hits < MAX_RESULTS; i++)
            begin
                case (act)
                    ACT_LIST:    hit = 1'b1;
                    ACT_YEAR_EQ: hit = (shadow_rec[i].year == yr);
                    ACT_YEAR_GE: hit = (shadow_rec[i].year >= yr);
                    default:     hit = models_match(shadow_rec[i].model, md & TEXT_KEEP);
                endcase
                if (hit)
                begin
                    // hold each match back until we know whether it is the final one
                    if (hits > 0)
                        pending_replies.push_back(held);
                    held.status = ST_RECORD;
                    held.rec    = shadow_rec[i];
                    held.pos    = i[POS_W-1:0];
                    held.last   = 1'b0;
                    hits++;
                end
            end
            if (hits == 0)
            begin
                r.status = ST_NONE;
                pending_replies.push_back(r);
            end
            else
            begin
                held.last = 1'b1;
                pending_replies.push_back(held);
            end
        end
    endtask

    task automatic compare_field(input string name, input logic [TEXT_W-1:0] want,
                                 input logic [TEXT_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (pending_replies.size() == 0)
            begin
                $display("%0t: reply with none outstanding, expected nothing actual status %0h",
                         $time, status);
                mismatches++;
            end
            else
            begin
                oldest_reply = pending_replies.pop_front();
                compare_field("status",       oldest_reply.status,    status);
                compare_field("out_year",     oldest_reply.rec.year,  out_year);
                compare_field("out_brand",    oldest_reply.rec.brand, out_brand);
                compare_field("out_model",    oldest_reply.rec.model, out_model);
                compare_field("out_plate",    oldest_reply.rec.plate, out_plate);
                compare_field("out_position", oldest_reply.pos,       out_position);
                compare_field("last",         oldest_reply.last,      last);
            end
        end
    end

    // One command transfer. Start stays high on return so that a following
    // command can go back to back.
    task automatic send_command(input logic [ACT_W-1:0]  act,
                                input logic [YEAR_W-1:0] yr,
                                input logic [TEXT_W-1:0] br,
                                input logic [TEXT_W-1:0] md,
                                input logic [TEXT_W-1:0] pl);
        int gap;
        @(negedge clk);
        if (gaps_on && $urandom_range(0, 99) < 13)
        begin
            // let the block go idle first so that the pause is seen
            start = 1'b0;
            while (busy)
                @(negedge clk);
            gap   = $urandom_range(1, 4);
            repeat (gap) @(negedge clk);
        end
        action     = act;
        key_year   = yr;
        brand_text = br;
        model_text = md;
        plate_text = pl;
        start      = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        apply_table_command(act, yr, br, md, pl);
    endtask

    function automatic logic [TEXT_W-1:0] random_text();
        logic [TEXT_W-1:0] t;
        int                len;
        int                k;
        t = '0;
        if ($urandom_range(0, 1) == 0)
        begin
            t = {$urandom, $urandom};
        end
        else
        begin
            len = $urandom_range(0, TEXT_CHARS);
            for (k = 0; k < len; k++)
                t[8*k +: 8] = 8'h41 + 8'($urandom_range(0, 25));
        end
        return t;
    endfunction

    function automatic logic [YEAR_W-1:0] random_year();
        logic [YEAR_W-1:0] y;
        case ($urandom_range(0, 3))
            0: y = ($urandom_range(0, 1) == 0) ? 14'd0 : 14'd9999;
            1: y = YEAR_W'($urandom_range(1995, 1999));
            2: y = YEAR_W'($urandom_range(0, 9999));
            default: y = (shadow_count > 0) ?
                         shadow_rec[$urandom_range(0, shadow_count - 1)].year :
                         YEAR_W'($urandom_range(0, 9999));
        endcase
        return y;
    endfunction

    task automatic send_random_query();
        logic [ACT_W-1:0]  act;
        logic [YEAR_W-1:0] yr;
        logic [TEXT_W-1:0] md;
        int                pick;
        int                k;
        bit                seen_zero;
        pick = $urandom_range(0, 99);
        act  = (pick < 15) ? ACT_LIST : (pick < 45) ? ACT_YEAR_EQ :
               (pick < 70) ? ACT_YEAR_GE : ACT_MODEL;
        yr   = random_year();
        md   = random_text();
        if (act == ACT_MODEL && shadow_count > 0 && $urandom_range(0, 99) < 75)
        begin
            md = shadow_rec[$urandom_range(0, shadow_count - 1)].model;
            // scramble the bytes past the terminator; they must not matter
            if ($urandom_range(0, 2) == 0)
            begin
                seen_zero = 1'b0;
                for (k = 0; k < TEXT_CHARS; k++)
                begin
                    if (seen_zero)
                        md[8*k +: 8] = 8'($urandom);
                    else if (md[8*k +: 8] == 8'h00)
                        seen_zero = 1'b1;
                end
            end
        end
        send_command(act, yr, random_text(), md, random_text());
    endtask

    task automatic test_empty_table_queries();
        send_command(ACT_LIST,    14'd0,    '0, '0, '0);
        send_command(ACT_YEAR_EQ, 14'd0,    '0, '0, '0);
        send_command(ACT_YEAR_GE, 14'd0,    '0, '0, '0);
        send_command(ACT_MODEL,   14'd9999, '1, '0, '1);
        // unused action codes: expect silence
        send_command(3'd5, 14'd1, '1, '1, '1);
        send_command(3'd6, 14'd2, '0, '0, '0);
        send_command(3'd7, 14'd3, '1, '1, '1);
    endtask

    task automatic test_directed_inserts();
        send_command(ACT_INSERT, 14'd0,    '0, '0, '0);
        send_command(ACT_INSERT, 14'd9999, '1, '1, '1);
        // same year goes in front of the existing one
        send_command(ACT_INSERT, 14'd9999, 64'h0000_0000_4146_4C41,
                     64'h0000_4149_4C55_4947, 64'h0000_3433_3231_4241);
        send_command(ACT_INSERT, 14'd0, random_text(), random_text(), random_text());
        // model with rubbish after its terminator
        send_command(ACT_INSERT, 14'd5000, random_text(),
                     64'hA5A5_A5A5_004F_4E55, random_text());
        send_command(ACT_INSERT, 14'd5000, random_text(),
                     64'h0000_0000_004F_4E55, random_text());
    endtask

    task automatic test_directed_queries();
        send_command(ACT_LIST,    14'd0,    '0, '0, '0);
        send_command(ACT_YEAR_EQ, 14'd9999, '0, '0, '0);
        send_command(ACT_YEAR_EQ, 14'd1234, '0, '0, '0);
        send_command(ACT_YEAR_GE, 14'd5000, '0, '0, '0);
        send_command(ACT_YEAR_GE, 14'd0,    '0, '0, '0);
        send_command(ACT_MODEL,   14'd0, '0, 64'h0000_0000_004F_4E55, '0);
        send_command(ACT_MODEL,   14'd0, '0, 64'h1234_5678_004F_4E55, '0);
        send_command(ACT_MODEL,   14'd0, '0, '0, '0);
        send_command(ACT_MODEL,   14'd0, '0, '1, '0);
        send_command(ACT_MODEL,   14'd0, '0, 64'h0000_0000_005A_5A5A, '0);
    endtask

    task automatic test_random_fill();
        while (shadow_count < CAPACITY_DEF)
        begin
            if ($urandom_range(0, 99) < 60)
                send_command(ACT_INSERT, random_year(), random_text(),
                             random_text(), random_text());
            else
                send_random_query();
        end
    endtask

    task automatic test_random_mixed();
        int n;
        int roll;
        n = 0;
        while (n < 375)
        begin
            // leave one long stretch with the sender never pausing
            gaps_on = !(n >= 150 && n < 250);
            roll    = $urandom_range(0, 99);
            if (roll < 3)
            begin
                send_command(3'($urandom_range(5, 7)), random_year(), random_text(),
                             random_text(), random_text());
            end
            else
            begin
                if (roll < 13)
                    send_command(ACT_INSERT, random_year(), random_text(),
                                 random_text(), random_text());
                else
                    send_random_query();
                n++;
            end
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_table_queries();
        test_directed_inserts();
        test_directed_queries();
        test_random_fill();
        test_random_mixed();

        @(negedge clk);
        start = 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending_replies.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
hdl/srt_pkg.sv
hdl/srt_ram.sv
hdl/srt_engine.sv
hdl/sorted_record_table_core.sv
hdl/srt_checker.sv
tb/tb.sv
